### rtl/core/assert_macros.svh
// Assertion macros for the safety fault supervisor RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SFS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SFS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sfs_pkg.sv
// Types and constants for the safety fault supervisor.
// No dependencies; used by every module of the block.
`default_nettype none

package sfs_pkg;

   // command codes
   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_SET_MODE = 3'd1;
   localparam logic [2:0] CMD_ESTOP    = 3'd2;
   localparam logic [2:0] CMD_RESET    = 3'd3;
   localparam logic [2:0] CMD_PING     = 3'd4;

   // requested mode argument codes
   localparam logic [2:0] ARG_IDLE   = 3'd0;
   localparam logic [2:0] ARG_HOLD   = 3'd1;
   localparam logic [2:0] ARG_TELEOP = 3'd2;

   // mode codes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_HOLD   = 2'd1;
   localparam logic [1:0] MODE_TELEOP = 2'd2;
   localparam logic [1:0] MODE_ESTOP  = 2'd3;

   // command result codes
   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_REFUSED = 2'd1;
   localparam logic [1:0] RES_BAD     = 2'd2;
   localparam logic [1:0] RES_NONE    = 2'd3;

   // fault bit positions
   localparam int unsigned FLT_LEADER   = 0;
   localparam int unsigned FLT_FOLLOWER = 1;
   localparam int unsigned FLT_OVERTEMP = 2;
   localparam int unsigned FLT_VOLTAGE  = 3;
   localparam int unsigned FLT_OVERRUN  = 4;
   localparam int unsigned FLT_STALL    = 5;
   localparam int unsigned FLT_ESTOP    = 6;

   localparam logic [6:0] BLOCK_HOLD_MASK   = 7'b110_1110;
   localparam logic [6:0] BLOCK_TELEOP_MASK = 7'b110_1111;

   // check timing and thresholds
   localparam logic [31:0] STALL_LIMIT_MS = 32'd200;
   localparam logic [2:0]  PERSIST_COUNT  = 3'd5;
   localparam logic [31:0] OVERRUN_LIMIT  = 32'd5;
   localparam logic [31:0] WINDOW_MS      = 32'd1000;

   // register indexes
   localparam logic [1:0] REG_COMM_FAIL_STREAK  = 2'd0;
   localparam logic [1:0] REG_TEMPERATURE_LIMIT = 2'd1;
   localparam logic [1:0] REG_VOLTAGE_MIN       = 2'd2;
   localparam logic [1:0] REG_VOLTAGE_MAX       = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [2:0]  mode_arg;
      logic [31:0] now_ms;
      logic        snapshot_ok;
      logic [31:0] cycle_count;
      logic [15:0] lead_fail_run;
      logic [15:0] foll_fail_run;
      logic        foll_data_ok;
      logic [7:0]  max_temp;
      logic [7:0]  min_volt;
      logic [7:0]  max_volt;
      logic [31:0] overrun_total;
   } req_type;

   typedef struct packed {
      logic [1:0] cmd_result;
      logic [1:0] mode_now;
      logic [6:0] fault_flags;
   } rsp_type;

   typedef struct packed {
      logic [15:0] comm_fail_streak;
      logic [7:0]  temperature_limit;
      logic [7:0]  voltage_min;
      logic [7:0]  voltage_max;
   } cfg_type;

   // supervisor mode and latched faults
   typedef struct packed {
      logic [1:0] mode;
      logic [6:0] faults;
   } sup_type;

   // snapshot check bookkeeping
   typedef struct packed {
      logic [31:0] last_cycle_seen;
      logic [31:0] last_advance_time;
      logic [2:0]  hot_ticks;
      logic [2:0]  badvolt_ticks;
      logic [31:0] overrun_base;
      logic [31:0] window_start;
   } chk_type;

endpackage

`default_nettype wire

### rtl/core/sfs_cmd.sv
// Command service for the safety fault supervisor.
// Depends on sfs_pkg for codes and the sup_type struct.
`default_nettype none

module sfs_cmd (
   input  wire logic [2:0]      cmd,
   input  wire logic [2:0]      mode_arg,
   input  wire sfs_pkg::sup_type sup_in,
   output sfs_pkg::sup_type     sup_out,
   output logic [1:0]           cmd_result
);

   always_comb begin
      sup_out    = sup_in;
      cmd_result = sfs_pkg::RES_OK;
      case (cmd)
         sfs_pkg::CMD_NONE: begin
            cmd_result = sfs_pkg::RES_NONE;
         end
         sfs_pkg::CMD_SET_MODE: begin
            if (mode_arg == sfs_pkg::ARG_IDLE) begin
               if (sup_in.mode == sfs_pkg::MODE_ESTOP) begin
                  cmd_result = sfs_pkg::RES_REFUSED;
               end else begin
                  sup_out.mode = sfs_pkg::MODE_IDLE;
               end
            end else if (mode_arg == sfs_pkg::ARG_TELEOP) begin
               if ((sup_in.faults & sfs_pkg::BLOCK_TELEOP_MASK) != '0) begin
                  cmd_result = sfs_pkg::RES_REFUSED;
               end else begin
                  sup_out.mode = sfs_pkg::MODE_TELEOP;
               end
            end else if (mode_arg == sfs_pkg::ARG_HOLD) begin
               if ((sup_in.faults & sfs_pkg::BLOCK_HOLD_MASK) != '0) begin
                  cmd_result = sfs_pkg::RES_REFUSED;
               end else begin
                  sup_out.mode = sfs_pkg::MODE_HOLD;
               end
            end else begin
               cmd_result = sfs_pkg::RES_BAD;
            end
         end
         sfs_pkg::CMD_ESTOP: begin
            sup_out.faults[sfs_pkg::FLT_ESTOP] = 1'b1;
            sup_out.mode = sfs_pkg::MODE_ESTOP;
         end
         sfs_pkg::CMD_RESET: begin
            sup_out.faults = '0;
            sup_out.mode   = sfs_pkg::MODE_IDLE;
         end
         sfs_pkg::CMD_PING: begin
            cmd_result = sfs_pkg::RES_OK;
         end
         default: begin
            cmd_result = sfs_pkg::RES_BAD;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/sfs_check.sv
// Snapshot checks: stall, bus streaks, persistence counters, overrun window.
// Depends on sfs_pkg for types and limits.
`default_nettype none

module sfs_check (
   input  wire sfs_pkg::req_type req,
   input  wire sfs_pkg::cfg_type cfg,
   input  wire sfs_pkg::sup_type sup_in,
   input  wire sfs_pkg::chk_type chk_in,
   output sfs_pkg::sup_type     sup_out,
   output sfs_pkg::chk_type     chk_out
);

   // latched faults may only lower the mode; estop always wins
   function automatic logic [1:0] lower_mode(input logic [1:0] mode, input logic [1:0] safe);
      logic [1:0] res;
      res = mode;
      if (safe == sfs_pkg::MODE_ESTOP) begin
         res = safe;
      end else if (safe == sfs_pkg::MODE_IDLE && mode != sfs_pkg::MODE_ESTOP) begin
         res = safe;
      end else if (safe == sfs_pkg::MODE_HOLD && mode == sfs_pkg::MODE_TELEOP) begin
         res = safe;
      end
      return res;
   endfunction

   logic [31:0] stall_age;
   logic [31:0] window_age;
   logic [31:0] overruns;
   logic        hot;
   logic        badv;
   logic [2:0]  hot_cnt;
   logic [2:0]  badv_cnt;

   assign stall_age  = req.now_ms - chk_in.last_advance_time;
   assign window_age = req.now_ms - chk_in.window_start;
   assign overruns   = req.overrun_total - chk_in.overrun_base;
   assign hot  = req.max_temp >= cfg.temperature_limit;
   assign badv = (req.min_volt < cfg.voltage_min) || (req.max_volt > cfg.voltage_max);
   assign hot_cnt  = !hot  ? 3'd0 : ((chk_in.hot_ticks == 3'd7) ? 3'd7 :
                                     chk_in.hot_ticks + 3'd1);
   assign badv_cnt = !badv ? 3'd0 : ((chk_in.badvolt_ticks == 3'd7) ? 3'd7 :
                                     chk_in.badvolt_ticks + 3'd1);

   always_comb begin
      sup_out = sup_in;
      chk_out = chk_in;
      if (req.snapshot_ok) begin
         if (req.cycle_count != chk_in.last_cycle_seen) begin
            chk_out.last_cycle_seen   = req.cycle_count;
            chk_out.last_advance_time = req.now_ms;
         end else if (stall_age > sfs_pkg::STALL_LIMIT_MS) begin
            sup_out.faults[sfs_pkg::FLT_STALL] = 1'b1;
            sup_out.mode = lower_mode(sup_out.mode, sfs_pkg::MODE_ESTOP);
         end

         if (req.lead_fail_run >= cfg.comm_fail_streak) begin
            sup_out.faults[sfs_pkg::FLT_LEADER] = 1'b1;
            sup_out.mode = lower_mode(sup_out.mode, sfs_pkg::MODE_HOLD);
         end
         if (req.foll_fail_run >= cfg.comm_fail_streak) begin
            sup_out.faults[sfs_pkg::FLT_FOLLOWER] = 1'b1;
            sup_out.mode = lower_mode(sup_out.mode, sfs_pkg::MODE_IDLE);
         end

         if (req.foll_data_ok) begin
            chk_out.hot_ticks     = hot_cnt;
            chk_out.badvolt_ticks = badv_cnt;
            if (hot_cnt >= sfs_pkg::PERSIST_COUNT) begin
               sup_out.faults[sfs_pkg::FLT_OVERTEMP] = 1'b1;
               sup_out.mode = lower_mode(sup_out.mode, sfs_pkg::MODE_IDLE);
            end
            if (badv_cnt >= sfs_pkg::PERSIST_COUNT) begin
               sup_out.faults[sfs_pkg::FLT_VOLTAGE] = 1'b1;
               sup_out.mode = lower_mode(sup_out.mode, sfs_pkg::MODE_IDLE);
            end
         end

         // overrun latches without forcing a mode
         if (window_age >= sfs_pkg::WINDOW_MS) begin
            if (overruns > sfs_pkg::OVERRUN_LIMIT) begin
               sup_out.faults[sfs_pkg::FLT_OVERRUN] = 1'b1;
            end
            chk_out.overrun_base = req.overrun_total;
            chk_out.window_start = req.now_ms;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/safety_fault_supervisor_top.sv
// rsp_valid is registered: an accepted request passes the input register and then the result
// register, and a full result register stalls until rsp_ready is high.
// Throughput: one request per cycle if rsp_ready is high; state updates at result stage entry.
// The input register can still take one request while a response waits for rsp_ready.
// Reset (synchronous, active high): mode idle, faults and check state zero,
// registers back to 3 / 70 / 45 / 140, both stages empty.
`default_nettype none
`include "assert_macros.svh"

module safety_fault_supervisor_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sfs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sfs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   logic             s1_valid_ff, s1_valid_in;
   sfs_pkg::req_type s1_req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   sfs_pkg::rsp_type rsp_ff;
   sfs_pkg::sup_type sup_ff;
   sfs_pkg::chk_type chk_ff;
   sfs_pkg::cfg_type cfg_ff, cfg_in;

   sfs_pkg::sup_type sup_cmd;
   sfs_pkg::sup_type sup_in;
   sfs_pkg::chk_type chk_in;
   logic [1:0]       cmd_result;
   logic             s1_advance;
   logic             req_accept;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   sfs_cmd u_cmd (
      .cmd        (s1_req_ff.cmd),
      .mode_arg   (s1_req_ff.mode_arg),
      .sup_in     (sup_ff),
      .sup_out    (sup_cmd),
      .cmd_result (cmd_result)
   );

   sfs_check u_check (
      .req     (s1_req_ff),
      .cfg     (cfg_ff),
      .sup_in  (sup_cmd),
      .chk_in  (chk_ff),
      .sup_out (sup_in),
      .chk_out (chk_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sfs_pkg::REG_COMM_FAIL_STREAK:  cfg_in.comm_fail_streak  = csr_wdata;
            sfs_pkg::REG_TEMPERATURE_LIMIT: cfg_in.temperature_limit = csr_wdata[7:0];
            sfs_pkg::REG_VOLTAGE_MIN:       cfg_in.voltage_min       = csr_wdata[7:0];
            sfs_pkg::REG_VOLTAGE_MAX:       cfg_in.voltage_max       = csr_wdata[7:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sup_ff.mode  <= sfs_pkg::MODE_IDLE;
         sup_ff.faults <= '0;
         chk_ff       <= '0;
         cfg_ff.comm_fail_streak  <= 16'd3;
         cfg_ff.temperature_limit <= 8'd70;
         cfg_ff.voltage_min       <= 8'd45;
         cfg_ff.voltage_max       <= 8'd140;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (s1_advance) begin
            sup_ff <= sup_in;
            chk_ff <= chk_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_advance) begin
         rsp_ff.cmd_result  <= cmd_result;
         rsp_ff.mode_now    <= sup_in.mode;
         rsp_ff.fault_flags <= sup_in.faults;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SFS_ASSERT_IMP(a_estop_has_cause, sup_ff.mode == sfs_pkg::MODE_ESTOP, (sup_ff.faults[sfs_pkg::FLT_ESTOP] || sup_ff.faults[sfs_pkg::FLT_STALL]), "estop mode without estop or stall fault")
   `SFS_ASSERT_IMP(a_teleop_clean, sup_ff.mode == sfs_pkg::MODE_TELEOP, ((sup_ff.faults & sfs_pkg::BLOCK_TELEOP_MASK) == '0), "teleop with blocking fault latched")
   `SFS_ASSERT_IMP(a_hold_clean, sup_ff.mode == sfs_pkg::MODE_HOLD, ((sup_ff.faults & sfs_pkg::BLOCK_HOLD_MASK) == '0), "hold with blocking fault latched")
   `SFS_ASSERT_NXT(a_advance_gives_rsp, s1_advance, rsp_valid_ff, "advanced request produced no response")
   `SFS_ASSERT_NXT(a_state_only_on_advance, !s1_valid_ff, ($stable(sup_ff) && $stable(chk_ff)), "supervisor state changed with no request in flight")

endmodule

`default_nettype wire
